>>> hw/rtl/kmnc_pkg.sv
// Shared types, constants and helper functions for the keyboard to MIDI note controller.
// Used by the controller, the datapath and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package kmnc_pkg;

  // Number of note keys, one bit per key in the held and sounding maps.
  localparam int unsigned NUM_KEYS = 18;

  // Message kinds on the output channel.
  localparam logic [1:0] MSG_NOTE_ON  = 2'd0;
  localparam logic [1:0] MSG_NOTE_OFF = 2'd1;
  localparam logic [1:0] MSG_CTRL     = 2'd2;
  localparam logic [1:0] MSG_REPORT   = 2'd3;

  // Which pending message the controller asks the datapath to send.
  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_SCAN   = 2'd1;
  localparam logic [1:0] SEL_CC     = 2'd2;
  localparam logic [1:0] SEL_REPORT = 2'd3;

  // Musical constants.
  localparam logic [6:0] SUSTAIN_CC = 7'd64;
  localparam logic [6:0] CC_MAX     = 7'd127;
  localparam logic [6:0] VEL_STEP   = 7'd10;
  localparam logic [6:0] VEL_FLOOR  = 7'd11;
  localparam logic [6:0] VEL_MIN    = 7'd1;
  localparam logic [6:0] VEL_RESET  = 7'd100;
  localparam logic [3:0] OCT_MAX    = 4'd8;
  localparam logic [3:0] OCT_RESET  = 4'd4;

  // Character codes of the control keys.
  localparam logic [7:0] KEY_OCT_DOWN = 8'h7A;  // z
  localparam logic [7:0] KEY_OCT_UP   = 8'h78;  // x
  localparam logic [7:0] KEY_VEL_DOWN = 8'h63;  // c
  localparam logic [7:0] KEY_VEL_UP   = 8'h76;  // v

  // Result of the note key lookup.
  typedef struct packed {
    logic       hit;
    logic [4:0] off;
  } key_map_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [1:0] sel;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first_pend;
    logic scan_pend;
    logic cc_pend;
    logic out_room;
  } dp_status_t;

  // Map a typed character to its semitone offset above the base octave.
  function automatic key_map_t key_lookup(input logic [7:0] ch);
    key_map_t m;
    m.hit = 1'b1;
    m.off = 5'd0;
    case (ch)
      8'h61: m.off = 5'd0;   // a
      8'h77: m.off = 5'd1;   // w
      8'h73: m.off = 5'd2;   // s
      8'h65: m.off = 5'd3;   // e
      8'h64: m.off = 5'd4;   // d
      8'h66: m.off = 5'd5;   // f
      8'h74: m.off = 5'd6;   // t
      8'h67: m.off = 5'd7;   // g
      8'h79: m.off = 5'd8;   // y
      8'h68: m.off = 5'd9;   // h
      8'h75: m.off = 5'd10;  // u
      8'h6A: m.off = 5'd11;  // j
      8'h6B: m.off = 5'd12;  // k
      8'h6F: m.off = 5'd13;  // o
      8'h6C: m.off = 5'd14;  // l
      8'h70: m.off = 5'd15;  // p
      8'h3B: m.off = 5'd16;  // semicolon
      8'h27: m.off = 5'd17;  // apostrophe
      default: m.hit = 1'b0;
    endcase
    return m;
  endfunction

  // Note number for an offset above an octave, capped at the top of the MIDI range.
  function automatic logic [6:0] note_of(input logic [3:0] oct, input logic [4:0] off);
    logic [8:0] sum;
    sum = {2'b00, oct, 3'b000} + {3'b000, oct, 2'b00} + {4'b0000, off};
    return (sum > {2'b00, CC_MAX}) ? CC_MAX : sum[6:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kmnc_key_if.sv
// Input channel carrying one key event per transfer.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface kmnc_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       key_down;
  logic       is_tab;

  modport source (output valid, output char_code, output key_down, output is_tab,
                  input ready);
  modport sink   (input valid, input char_code, input key_down, input is_tab,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kmnc_msg_if.sv
// Output channel carrying one MIDI-like message or event report per transfer.
// Stand-alone interface; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface kmnc_msg_if;
  logic       valid;
  logic       ready;
  logic [1:0] msg_kind;
  logic [6:0] note_number;
  logic [6:0] msg_value;
  logic       handled;
  logic [3:0] octave_now;
  logic [6:0] velocity_now;
  logic       sustain_now;
  logic       last;

  modport source (output valid, output msg_kind, output note_number, output msg_value,
                  output handled, output octave_now, output velocity_now,
                  output sustain_now, output last, input ready);
  modport sink   (input valid, input msg_kind, input note_number, input msg_value,
                  input handled, input octave_now, input velocity_now,
                  input sustain_now, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kmnc_datapath.sv
// Datapath: key state, per-event message bookkeeping and the output register.
// Depends on kmnc_pkg and kmnc_msg_if; driven by commands from kmnc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module kmnc_datapath
  import kmnc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] char_code,
  input  wire logic       key_down,
  input  wire logic       is_tab,
  input  wire ctl_cmd_t   cmd,
  output dp_status_t      status,
  kmnc_msg_if.source      msg_out
);

  // Persistent key state.
  logic [NUM_KEYS-1:0] keys_held;
  logic [NUM_KEYS-1:0] notes_sounding;
  logic [3:0]          base_octave;
  logic [6:0]          note_velocity;
  logic                sustain_on;

  // Messages still owed for the current event.
  logic                first_pend;
  logic [1:0]          first_kind;
  logic [6:0]          first_note;
  logic [6:0]          first_value;
  logic [NUM_KEYS-1:0] scan_mask;
  logic [3:0]          scan_oct;
  logic                cc_pend;
  logic                handled;

  // Output register.
  logic       out_valid;
  logic [1:0] out_kind;
  logic [6:0] out_note;
  logic [6:0] out_value;
  logic       out_handled;
  logic [3:0] out_octave;
  logic [6:0] out_velocity;
  logic       out_sustain;
  logic       out_last;

  // Next values of the key state and of the event bookkeeping.
  logic [NUM_KEYS-1:0] keys_held_next;
  logic [NUM_KEYS-1:0] notes_sounding_next;
  logic [3:0]          base_octave_next;
  logic [6:0]          note_velocity_next;
  logic                sustain_on_next;
  logic                first_pend_next;
  logic [1:0]          first_kind_next;
  logic [6:0]          first_note_next;
  logic [6:0]          first_value_next;
  logic [NUM_KEYS-1:0] scan_mask_next;
  logic [3:0]          scan_oct_next;
  logic                cc_pend_next;
  logic                handled_next;

  key_map_t            key;
  logic [NUM_KEYS-1:0] key_bit;
  logic [NUM_KEYS-1:0] rel_mask;
  logic [7:0]          vel_sum;
  logic [NUM_KEYS-1:0] scan_low;
  logic [4:0]          scan_idx;
  logic                out_room;

  assign key      = key_lookup(char_code);
  assign key_bit  = {{(NUM_KEYS-1){1'b0}}, 1'b1} << key.off;
  assign rel_mask = notes_sounding & ~keys_held;
  assign vel_sum  = {1'b0, note_velocity} + {1'b0, VEL_STEP};

  // Decode an accepted event into new state and the messages it owes.
  always_comb begin
    keys_held_next      = keys_held;
    notes_sounding_next = notes_sounding;
    base_octave_next    = base_octave;
    note_velocity_next  = note_velocity;
    sustain_on_next     = sustain_on;
    first_pend_next     = 1'b0;
    first_kind_next     = MSG_NOTE_ON;
    first_note_next     = note_of(base_octave, key.off);
    first_value_next    = 7'd0;
    scan_mask_next      = '0;
    scan_oct_next       = base_octave;
    cc_pend_next        = 1'b0;
    handled_next        = 1'b0;
    if (key.hit) begin
      handled_next = 1'b1;
      if (key_down) begin
        if ((keys_held & key_bit) == '0) begin
          keys_held_next      = keys_held | key_bit;
          notes_sounding_next = notes_sounding | key_bit;
          first_pend_next     = 1'b1;
          first_value_next    = note_velocity;
        end
      end else begin
        keys_held_next = keys_held & ~key_bit;
        if (!sustain_on) begin
          notes_sounding_next = notes_sounding & ~key_bit;
          first_pend_next     = 1'b1;
          first_kind_next     = MSG_NOTE_OFF;
        end
      end
    end else if (key_down) begin
      if (char_code == KEY_OCT_DOWN || char_code == KEY_OCT_UP) begin
        handled_next = 1'b1;
        if (char_code == KEY_OCT_DOWN) begin
          if (base_octave != 4'd0) base_octave_next = base_octave - 4'd1;
        end else begin
          if (base_octave < OCT_MAX) base_octave_next = base_octave + 4'd1;
        end
        // Release everything at the octave in force before the step.
        scan_mask_next      = notes_sounding;
        notes_sounding_next = '0;
        keys_held_next      = '0;
        if (sustain_on) begin
          sustain_on_next = 1'b0;
          cc_pend_next    = 1'b1;
        end
      end else if (char_code == KEY_VEL_DOWN) begin
        handled_next       = 1'b1;
        note_velocity_next = (note_velocity > VEL_FLOOR) ? note_velocity - VEL_STEP : VEL_MIN;
      end else if (char_code == KEY_VEL_UP) begin
        handled_next       = 1'b1;
        note_velocity_next = (vel_sum > {1'b0, CC_MAX}) ? CC_MAX : vel_sum[6:0];
      end else if (is_tab) begin
        handled_next     = 1'b1;
        sustain_on_next  = !sustain_on;
        first_pend_next  = 1'b1;
        first_kind_next  = MSG_CTRL;
        first_note_next  = SUSTAIN_CC;
        first_value_next = sustain_on ? 7'd0 : CC_MAX;
        // Sustain turning off releases notes whose keys are up.
        if (sustain_on) begin
          scan_mask_next      = rel_mask;
          notes_sounding_next = notes_sounding & ~rel_mask;
        end
      end
    end
  end

  // Lowest pending note of the release scan.
  always_comb begin
    scan_low = scan_mask & (~scan_mask + {{(NUM_KEYS-1){1'b0}}, 1'b1});
    scan_idx = 5'd0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (scan_low[i]) scan_idx = scan_idx | 5'(i);
    end
  end

  assign out_room = !out_valid || msg_out.ready;

  assign status.first_pend = first_pend;
  assign status.scan_pend  = (scan_mask != '0);
  assign status.cc_pend    = cc_pend;
  assign status.out_room   = out_room;

  // Key state and event bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      keys_held      <= '0;
      notes_sounding <= '0;
      base_octave    <= OCT_RESET;
      note_velocity  <= VEL_RESET;
      sustain_on     <= 1'b0;
      first_pend     <= 1'b0;
      scan_mask      <= '0;
      cc_pend        <= 1'b0;
    end else if (cmd.load) begin
      keys_held      <= keys_held_next;
      notes_sounding <= notes_sounding_next;
      base_octave    <= base_octave_next;
      note_velocity  <= note_velocity_next;
      sustain_on     <= sustain_on_next;
      first_pend     <= first_pend_next;
      scan_mask      <= scan_mask_next;
      cc_pend        <= cc_pend_next;
    end else if (cmd.emit) begin
      case (cmd.sel)
        SEL_FIRST:  first_pend <= 1'b0;
        SEL_SCAN:   scan_mask  <= scan_mask & ~scan_low;
        SEL_CC:     cc_pend    <= 1'b0;
        default:    ;
      endcase
    end
  end

  // Payload of the event bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_kind  <= first_kind_next;
      first_note  <= first_note_next;
      first_value <= first_value_next;
      scan_oct    <= scan_oct_next;
      handled     <= handled_next;
    end
  end

  // Output valid: set when a message is loaded, cleared once it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (msg_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload. The report fields are zero on every message but the report.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_handled  <= (cmd.sel == SEL_REPORT) ? handled : 1'b0;
      out_octave   <= (cmd.sel == SEL_REPORT) ? base_octave : 4'd0;
      out_velocity <= (cmd.sel == SEL_REPORT) ? note_velocity : 7'd0;
      out_sustain  <= (cmd.sel == SEL_REPORT) ? sustain_on : 1'b0;
      out_last     <= (cmd.sel == SEL_REPORT);
      case (cmd.sel)
        SEL_FIRST: begin
          out_kind  <= first_kind;
          out_note  <= first_note;
          out_value <= first_value;
        end
        SEL_SCAN: begin
          out_kind  <= MSG_NOTE_OFF;
          out_note  <= note_of(scan_oct, scan_idx);
          out_value <= 7'd0;
        end
        SEL_CC: begin
          out_kind  <= MSG_CTRL;
          out_note  <= SUSTAIN_CC;
          out_value <= 7'd0;
        end
        default: begin
          out_kind  <= MSG_REPORT;
          out_note  <= 7'd0;
          out_value <= 7'd0;
        end
      endcase
    end
  end

  assign msg_out.valid        = out_valid;
  assign msg_out.msg_kind     = out_kind;
  assign msg_out.note_number  = out_note;
  assign msg_out.msg_value    = out_value;
  assign msg_out.handled      = out_handled;
  assign msg_out.octave_now   = out_octave;
  assign msg_out.velocity_now = out_velocity;
  assign msg_out.sustain_now  = out_sustain;
  assign msg_out.last         = out_last;

  // A message is never loaded over one that has not been transferred.
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> out_room)
    else $error("message loaded while output register is full");

  // Every held key is also sounding.
  assert property (@(posedge clk) disable iff (rst) (keys_held & ~notes_sounding) == '0)
    else $error("held key without a sounding note");

  // The report closes the event only after all owed messages went out.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.sel == SEL_REPORT |-> !first_pend && scan_mask == '0 && !cc_pend)
    else $error("report sent with messages still pending");

  // Each scan step retires exactly one note.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.sel == SEL_SCAN |=>
      $countones(scan_mask) == $countones($past(scan_mask)) - 1)
    else $error("release scan did not retire one note");

  // Octave and velocity stay in range.
  assert property (@(posedge clk) disable iff (rst)
    base_octave <= OCT_MAX && note_velocity != 7'd0)
    else $error("octave or velocity out of range");

endmodule

`default_nettype wire

>>> hw/rtl/kmnc_ctrl.sv
// Controller: accepts key events and sequences the messages of each event.
// Depends on kmnc_pkg; commands kmnc_datapath through ctl_cmd_t and dp_status_t.
`timescale 1ns / 1ps
`default_nettype none

module kmnc_ctrl
  import kmnc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  assign in_ready = (state == ST_IDLE);

  // Pick the next owed message in order: first message, release scan,
  // sustain controller, then the closing report.
  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.emit   = 1'b0;
    cmd.sel    = SEL_REPORT;
    if (status.first_pend)     cmd.sel = SEL_FIRST;
    else if (status.scan_pend) cmd.sel = SEL_SCAN;
    else if (status.cc_pend)   cmd.sel = SEL_CC;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_room) begin
          cmd.emit = 1'b1;
          if (cmd.sel == SEL_REPORT) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Each event is closed by a report, after which a new event can be taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.sel == SEL_REPORT |=> in_ready)
    else $error("controller did not return to idle after the report");

  // An accepted event always produces at least one message next.
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> !in_ready)
    else $error("event accepted without sequencing its messages");

  // Load and emit never coincide.
  assert property (@(posedge clk) disable iff (rst) !(cmd.load && cmd.emit))
    else $error("load and emit in the same cycle");

endmodule

`default_nettype wire

>>> hw/rtl/keyboard_to_midi_note_controller_unit.sv
// Keyboard to MIDI note controller: turns key events into note, sustain and report messages.
// Top level; depends on kmnc_pkg, kmnc_key_if, kmnc_msg_if, kmnc_ctrl and kmnc_datapath.
//
// Each key event is first accepted and decoded, then its messages are loaded into the output
// register one by one, the closing report included: only the report for an event that owes
// nothing else, up to 20 messages for an octave step with all 18 notes sounding and sustain on.
// The output register takes one message per cycle while the message channel does not stall,
// as the controller walks the pending note-offs lowest first. A new event is accepted as soon
// as its predecessor's report sits in the output register, while that report still waits to be transferred.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_to_midi_note_controller_unit
  import kmnc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  kmnc_key_if.sink  key_in,
  kmnc_msg_if.source msg_out
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       in_ready;

  assign key_in.ready = in_ready;

  kmnc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  kmnc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .char_code (key_in.char_code),
    .key_down  (key_in.key_down),
    .is_tab    (key_in.is_tab),
    .cmd       (cmd),
    .status    (status),
    .msg_out   (msg_out)
  );

endmodule

`default_nettype wire

>>> tb/sv/kmnc_event_checker.sv
// Checker for the keyboard to MIDI note controller: watches the key and message channels,
// predicts every message from the accepted key events and compares field by field.
// Depends on kmnc_pkg, kmnc_key_if and kmnc_msg_if.
`timescale 1ns / 1ps

module kmnc_event_checker
  import kmnc_pkg::*;
#(
  parameter logic [8*NUM_KEYS-1:0] KEY_CHARS = '0
) (
  input  logic clk,
  input  logic rst,
  kmnc_key_if  key_mon,
  kmnc_msg_if  msg_mon,
  output int   mismatch_count,
  output int   pending_msgs
);

  localparam int SEMITONES_PER_OCTAVE = 12;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] value;
    logic       handled;
    logic [3:0] octave;
    logic [6:0] velocity;
    logic       sustain;
    logic       last;
  } midi_msg_t;

  midi_msg_t           expected_msgs[$];
  logic [NUM_KEYS-1:0] held_keys;
  logic [NUM_KEYS-1:0] sounding_notes;
  logic [3:0]          cur_octave;
  logic [6:0]          cur_velocity;
  logic                sustain_on;

  // Note number for a key offset above an octave, capped at the top of the range.
  function automatic logic [6:0] pitch_of(input logic [3:0] oct, input int offset);
    int n;
    n = int'(oct) * SEMITONES_PER_OCTAVE + offset;
    return (n > int'(CC_MAX)) ? CC_MAX : 7'(n);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic queue_msg(input logic [1:0] kind, input logic [6:0] note,
                           input logic [6:0] value);
    midi_msg_t m;
    m = '0;
    m.kind = kind;
    m.note = note;
    m.value = value;
    expected_msgs.push_back(m);
  endtask

  // Note-offs for every set bit, lowest offset first.
  task automatic queue_note_offs(input logic [NUM_KEYS-1:0] mask, input logic [3:0] oct);
    for (int i = 0; i < NUM_KEYS; i++)
      if (mask[i]) queue_msg(MSG_NOTE_OFF, pitch_of(oct, i), 7'd0);
  endtask

  // Update the shadow state for one key event and queue the messages it causes.
  task automatic predict_event(input logic [7:0] ch, input logic down, input logic tab);
    int                  offset;
    logic                handled;
    logic [NUM_KEYS-1:0] key_bit;
    logic [NUM_KEYS-1:0] freed;
    logic [3:0]          prev_octave;
    midi_msg_t           rpt;
    offset = -1;
    handled = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++)
      if (KEY_CHARS[8*(NUM_KEYS-1-i) +: 8] == ch) offset = i;

    if (offset >= 0) begin
      // Note keys are handled on press and release alike.
      handled = 1'b1;
      key_bit = '0;
      key_bit[offset] = 1'b1;
      if (down) begin
        if (!held_keys[offset]) begin
          held_keys |= key_bit;
          sounding_notes |= key_bit;
          queue_msg(MSG_NOTE_ON, pitch_of(cur_octave, offset), cur_velocity);
        end
      end else begin
        held_keys &= ~key_bit;
        if (!sustain_on) begin
          sounding_notes &= ~key_bit;
          queue_msg(MSG_NOTE_OFF, pitch_of(cur_octave, offset), 7'd0);
        end
      end
    end else if (down) begin
      if (ch == KEY_OCT_DOWN || ch == KEY_OCT_UP) begin
        // Octave step silences everything at the old octave and drops sustain.
        prev_octave = cur_octave;
        if (ch == KEY_OCT_DOWN && cur_octave != 4'd0) cur_octave--;
        if (ch == KEY_OCT_UP && cur_octave < OCT_MAX) cur_octave++;
        queue_note_offs(sounding_notes, prev_octave);
        sounding_notes = '0;
        held_keys = '0;
        if (sustain_on) begin
          sustain_on = 1'b0;
          queue_msg(MSG_CTRL, SUSTAIN_CC, 7'd0);
        end
        handled = 1'b1;
      end else if (ch == KEY_VEL_DOWN) begin
        cur_velocity = (cur_velocity > VEL_STEP + 7'd1) ? cur_velocity - VEL_STEP : VEL_MIN;
        handled = 1'b1;
      end else if (ch == KEY_VEL_UP) begin
        cur_velocity = (int'(cur_velocity) + int'(VEL_STEP) > int'(CC_MAX)) ?
                       CC_MAX : cur_velocity + VEL_STEP;
        handled = 1'b1;
      end else if (tab) begin
        // Sustain toggle; turning it off frees notes whose keys are up.
        sustain_on = !sustain_on;
        queue_msg(MSG_CTRL, SUSTAIN_CC, sustain_on ? CC_MAX : 7'd0);
        if (!sustain_on) begin
          freed = sounding_notes & ~held_keys;
          queue_note_offs(freed, cur_octave);
          sounding_notes &= ~freed;
        end
        handled = 1'b1;
      end
    end

    // Every event closes with a report of the state after it.
    rpt = '0;
    rpt.kind = MSG_REPORT;
    rpt.handled = handled;
    rpt.octave = cur_octave;
    rpt.velocity = cur_velocity;
    rpt.sustain = sustain_on;
    rpt.last = 1'b1;
    expected_msgs.push_back(rpt);
  endtask

  // Compare one transferred message with the oldest expectation.
  task automatic check_msg();
    midi_msg_t want;
    if (expected_msgs.size() == 0) begin
      report_mismatch($sformatf("unexpected message, kind %0d note %0d",
                                msg_mon.msg_kind, msg_mon.note_number));
    end else begin
      want = expected_msgs.pop_front();
      check_field("msg_kind", msg_mon.msg_kind, want.kind);
      check_field("note_number", msg_mon.note_number, want.note);
      check_field("msg_value", msg_mon.msg_value, want.value);
      check_field("handled", msg_mon.handled, want.handled);
      check_field("octave_now", msg_mon.octave_now, want.octave);
      check_field("velocity_now", msg_mon.velocity_now, want.velocity);
      check_field("sustain_now", msg_mon.sustain_now, want.sustain);
      check_field("last", msg_mon.last, want.last);
    end
  endtask

  // Predict on each key transfer, check on each message transfer.
  always @(posedge clk) begin
    if (rst) begin
      expected_msgs.delete();
      held_keys = '0;
      sounding_notes = '0;
      cur_octave = OCT_RESET;
      cur_velocity = VEL_RESET;
      sustain_on = 1'b0;
    end else begin
      if (key_mon.valid && key_mon.ready)
        predict_event(key_mon.char_code, key_mon.key_down, key_mon.is_tab);
      if (msg_mon.valid && msg_mon.ready) check_msg();
    end
    pending_msgs <= expected_msgs.size();
  end

endmodule

>>> tb/sv/tb_keyboard_to_midi_note_controller_unit.sv
// Testbench top for the keyboard to MIDI note controller: drives key events, stalls the
// message channel at random and gives the verdict. Depends on kmnc_pkg, the two channel
// interfaces, the controller and kmnc_event_checker.
`timescale 1ns / 1ps

module tb_keyboard_to_midi_note_controller_unit;
  import kmnc_pkg::*;

  localparam logic [8*NUM_KEYS-1:0] NOTE_KEY_CHARS = "awsedftgyhujkolp;'";
  localparam logic [7:0] TAB_CHAR = 8'h09;
  localparam logic [7:0] UNMAPPED_CHAR = 8'h71;  // q
  localparam int RANDOM_EVENTS = 480;
  localparam int MAX_WAIT = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   pending_msgs;
  int   src_gap_max;
  int   sink_stall_max;
  int   stall_left;
  int   keys_sent;
  int   noise_sent;
  int   idle_cycles;

  kmnc_key_if key_ch ();
  kmnc_msg_if msg_ch ();

  keyboard_to_midi_note_controller_unit uut (
    .clk    (clk),
    .rst    (rst),
    .key_in (key_ch),
    .msg_out(msg_ch)
  );

  kmnc_event_checker #(
    .KEY_CHARS(NOTE_KEY_CHARS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .key_mon       (key_ch),
    .msg_mon       (msg_ch),
    .mismatch_count(mismatch_count),
    .pending_msgs  (pending_msgs)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] note_key(input int idx);
    return NOTE_KEY_CHARS[8*(NUM_KEYS-1-idx) +: 8];
  endfunction

  // Offer one key event after a random gap and hold it until the transfer.
  task automatic send_key(input logic [7:0] ch, input logic down, input logic tab);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      key_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.char_code <= ch;
    key_ch.key_down <= down;
    key_ch.is_tab <= tab;
    do @(posedge clk); while (!key_ch.ready);
    keys_sent++;
  endtask

  // Hold off the sender until every predicted message has come out.
  task automatic wait_for_drain();
    key_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_msgs != 0);
  endtask

  // Press a handful of keys (sometimes all of them), maybe hold with sustain,
  // release some, then sometimes close with a sustain toggle or an octave step.
  task automatic play_chord();
    int pressed[$];
    int n;
    int start;
    int k;
    if ($urandom_range(0, 3) == 0) begin
      start = $urandom_range(0, NUM_KEYS - 1);
      for (int i = 0; i < NUM_KEYS; i++) pressed.push_back((start + i) % NUM_KEYS);
    end else begin
      n = $urandom_range(1, 5);
      repeat (n) pressed.push_back($urandom_range(0, NUM_KEYS - 1));
    end
    foreach (pressed[j]) send_key(note_key(pressed[j]), 1'b1, $urandom_range(0, 7) == 0);
    if ($urandom_range(0, 1)) send_key(TAB_CHAR, 1'b1, 1'b1);
    foreach (pressed[j])
      if ($urandom_range(0, 1)) send_key(note_key(pressed[j]), 1'b0, $urandom_range(0, 7) == 0);
    k = $urandom_range(0, 3);
    case (k)
      0: send_key(TAB_CHAR, 1'b1, 1'b1);
      1: send_key(KEY_OCT_DOWN, 1'b1, 1'b0);
      2: send_key(KEY_OCT_UP, 1'b1, 1'b0);
      default: ;
    endcase
  endtask

  // Message sink: after each transfer, stall for a random number of cycles.
  initial begin
    msg_ch.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        msg_ch.ready <= 1'b0;
        stall_left = 0;
      end else if (msg_ch.valid && msg_ch.ready) begin
        stall_left = $urandom_range(0, sink_stall_max);
        msg_ch.ready <= (stall_left == 0);
      end else if (stall_left > 1) begin
        stall_left--;
      end else begin
        stall_left = 0;
        msg_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((key_ch.valid && key_ch.ready) || (msg_ch.valid && msg_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus: directed events first, then random sequences under changing idling.
  initial begin
    int pick;
    int len;
    logic [7:0] ch;
    key_ch.valid = 1'b0;
    key_ch.char_code = 8'd0;
    key_ch.key_down = 1'b0;
    key_ch.is_tab = 1'b0;
    rst = 1'b1;
    src_gap_max = MAX_WAIT;
    sink_stall_max = MAX_WAIT;
    keys_sent = 0;
    noise_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed corners.
    send_key(note_key(0), 1'b1, 1'b0);                // lowest key
    send_key(note_key(0), 1'b1, 1'b0);                // press while already held
    send_key(note_key(NUM_KEYS - 1), 1'b1, 1'b0);     // highest key
    send_key(note_key(0), 1'b0, 1'b0);                // release, sustain off
    send_key(TAB_CHAR, 1'b1, 1'b1);                   // sustain on
    send_key(note_key(NUM_KEYS - 1), 1'b0, 1'b0);     // release held back by sustain
    send_key(note_key(1), 1'b0, 1'b0);                // release of a key never pressed
    send_key(TAB_CHAR, 1'b1, 1'b1);                   // sustain off frees the top note
    send_key(TAB_CHAR, 1'b0, 1'b1);                   // tab release is ignored
    send_key(UNMAPPED_CHAR, 1'b1, 1'b0);
    send_key(UNMAPPED_CHAR, 1'b0, 1'b0);
    send_key(KEY_OCT_DOWN, 1'b0, 1'b0);               // control key release is ignored
    repeat (3) send_key(KEY_VEL_UP, 1'b1, 1'b0);      // clamps at the top
    send_key(KEY_VEL_DOWN, 1'b1, 1'b1);               // velocity key wins over tab
    send_key(note_key(2), 1'b1, 1'b1);                // note key wins over tab
    send_key(TAB_CHAR, 1'b1, 1'b1);
    send_key(KEY_OCT_UP, 1'b1, 1'b0);                 // step with a note and sustain on
    send_key(8'hFF, 1'b1, 1'b1);                      // all-ones code acting as tab
    send_key(8'h00, 1'b1, 1'b0);
    send_key(8'h00, 1'b0, 1'b1);
    send_key(KEY_OCT_DOWN, 1'b1, 1'b1);               // octave key wins over tab
    wait_for_drain();

    // Random sequences; noise of random codes does not count toward the total.
    keys_sent = 0;
    while (keys_sent - noise_sent < RANDOM_EVENTS) begin
      if ($urandom_range(0, 5) == 0) begin
        src_gap_max = $urandom_range(0, 1) ? MAX_WAIT : 0;
        sink_stall_max = $urandom_range(0, 1) ? MAX_WAIT : 0;
      end
      if ($urandom_range(0, 14) == 0) wait_for_drain();
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: play_chord();
        4: begin
          ch = $urandom_range(0, 1) ? KEY_OCT_DOWN : KEY_OCT_UP;
          len = $urandom_range(1, 9);
          repeat (len) send_key(ch, 1'b1, 1'($urandom_range(0, 1)));
        end
        5: begin
          ch = $urandom_range(0, 1) ? KEY_VEL_DOWN : KEY_VEL_UP;
          len = $urandom_range(1, 13);
          repeat (len) send_key(ch, 1'b1, 1'($urandom_range(0, 1)));
        end
        6: begin
          send_key(TAB_CHAR, 1'b1, 1'b1);
          if ($urandom_range(0, 1)) send_key(TAB_CHAR, 1'b0, 1'b1);
        end
        7: begin
          send_key(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
          noise_sent++;
        end
        default:
          send_key(note_key($urandom_range(0, NUM_KEYS - 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 7) == 0);
      endcase
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_msgs == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/kmnc_pkg.sv
hw/rtl/kmnc_key_if.sv
hw/rtl/kmnc_msg_if.sv
hw/rtl/kmnc_datapath.sv
hw/rtl/kmnc_ctrl.sv
hw/rtl/keyboard_to_midi_note_controller_unit.sv
tb/sv/kmnc_event_checker.sv
tb/sv/tb_keyboard_to_midi_note_controller_unit.sv
